>>> rtl/core/pabu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pabu_pkg
// Types, constants and the packed two-channel blend for the ARGB 2x upscaler.
// ----------------------------------------------------------------------------
package pabu_pkg;

    localparam int unsigned MAX_WIDTH_DEF   = 2048;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam int unsigned PIX_W   = 32;
    localparam int unsigned COL_W   = 11;
    localparam int unsigned ROW_W   = 11;
    localparam int unsigned WGT_W   = 9;

    localparam logic [31:0]      MASK_AG      = 32'hff00ff00;
    localparam logic [31:0]      MASK_RB      = 32'h00ff00ff;
    localparam logic [23:0]      PAIR_MASK    = 24'hff00ff;
    localparam logic [WGT_W-1:0] WEIGHT_ONE   = 9'h100;
    localparam logic [WGT_W-1:0] WEIGHT_RESET = 9'd128;

    typedef struct packed {
        logic [PIX_W-1:0] upper_pixel;
        logic [PIX_W-1:0] lower_pixel;
        logic [ROW_W-1:0] row_index;
        logic             row_end;
    } pabu_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row_out;
        logic             last;
    } pabu_out_t;

    // one quad to blend: left/right columns of the upper and lower rows
    typedef struct packed {
        logic [PIX_W-1:0] left_up;
        logic [PIX_W-1:0] right_up;
        logic [PIX_W-1:0] left_lo;
        logic [PIX_W-1:0] right_lo;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row_out;
        logic             last;
    } pabu_job_t;

    // A/G and R/B share one multiply each; lanes are 16 bits apart and a
    // lane sum never exceeds 255*256, so no carry crosses lanes.
    function automatic logic [31:0] mix_pair(input logic [31:0] a,
                                             input logic [31:0] b,
                                             input logic [WGT_W-1:0] w);
        logic [23:0]      ag0;
        logic [23:0]      rb0;
        logic [23:0]      ag1;
        logic [23:0]      rb1;
        logic [WGT_W-1:0] wn;
        logic [32:0]      ag_sum;
        logic [32:0]      rb_sum;
        logic [23:0]      ag;
        logic [23:0]      rb;
        ag0    = a[31:8] & PAIR_MASK;
        rb0    = a[23:0] & PAIR_MASK;
        ag1    = b[31:8] & PAIR_MASK;
        rb1    = b[23:0] & PAIR_MASK;
        wn     = WEIGHT_ONE - w;
        ag_sum = 33'(ag0 * w) + 33'(ag1 * wn);
        rb_sum = 33'(rb0 * w) + 33'(rb1 * wn);
        ag     = ag_sum[31:8] & PAIR_MASK;
        rb     = rb_sum[31:8] & PAIR_MASK;
        mix_pair = ({ag, 8'h00} & MASK_AG) | ({8'h00, rb} & MASK_RB);
    endfunction

endpackage

>>> rtl/core/packed_argb_bilinear_upscale_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_argb_bilinear_upscale_unit
// 2x bilinear upscaler for packed ARGB8888 column pairs with a single programmable weight.
// ----------------------------------------------------------------------------
// Each input item is one source column (rows r and r+1). The block emits one
// value per 2x2 destination quad: column c-1 once column c arrives, and at
// row end also the last column blended with column 0 (flagged last). It
// takes one item per clock while each item yields at most one result and
// no stall occurs; a row-end item that yields two holds off the next item,
// as the job queue takes one job per cycle. A result passes the front's
// pending job register, queue, vertical-mix stage and horizontal-mix output
// register; a row end's second result follows the first. The weight is
// saturated to 256 and may only be written while the block is idle.
module packed_argb_bilinear_upscale_unit import pabu_pkg::*; #(
    parameter int unsigned MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [WGT_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  pabu_in_t         s_item,
    output logic             m_valid,
    input  logic             m_ready,
    output pabu_out_t        m_item
);

    logic [WGT_W-1:0] weight_reg, weight_next;
    logic [WGT_W-1:0] weight_sat;
    logic             fq_valid;
    logic             fq_ready;
    pabu_job_t        fq_job;
    logic             qb_valid;
    logic             qb_ready;
    pabu_job_t        qb_job;

    assign weight_next = cfg_wr_en ? cfg_wr_data : weight_reg;
    assign weight_sat  = (weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : weight_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= WEIGHT_RESET;
        end else begin
            weight_reg <= weight_next;
        end
    end

    pabu_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    pabu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_job   (fq_job),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_job   (qb_job)
    );

    pabu_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .weight    (weight_sat),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

>>> rtl/core/pabu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pabu_front
// Tracks the column position and previous/first column pairs, turns each
// input item into zero, one or two blend jobs and feeds them to the queue.
// ----------------------------------------------------------------------------
module pabu_front import pabu_pkg::*; #(
    parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  pabu_in_t  s_item,
    output logic      job_valid,
    input  logic      job_ready,
    output pabu_job_t job
);

    localparam int unsigned CNT_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_WIDTH - 1);

    logic [CNT_W-1:0] cnt_reg,      cnt_next;
    logic [31:0]      prev_up_reg,  prev_up_next;
    logic [31:0]      prev_lo_reg,  prev_lo_next;
    logic [31:0]      first_up_reg, first_up_next;
    logic [31:0]      first_lo_reg, first_lo_next;
    logic [1:0]       pend_cnt_reg, pend_cnt_next;
    pabu_job_t        pend_a_reg,   pend_a_next;
    pabu_job_t        pend_b_reg,   pend_b_next;

    logic             accept;
    logic             push;
    logic             has_left;
    logic [31:0]      first_up_eff;
    logic [31:0]      first_lo_eff;
    logic [CNT_W-1:0] cnt_prev;
    logic [CNT_W+COL_W-1:0] col_cur_ext;
    logic [CNT_W+COL_W-1:0] col_prev_ext;
    pabu_job_t        job_left;
    pabu_job_t        job_end;

    assign push      = (pend_cnt_reg != 2'd0) && job_ready;
    assign s_ready   = (pend_cnt_reg == 2'd0) || ((pend_cnt_reg == 2'd1) && job_ready);
    assign accept    = s_valid && s_ready;
    assign job_valid = (pend_cnt_reg != 2'd0);
    assign job       = pend_a_reg;

    assign has_left     = (cnt_reg != '0);
    assign first_up_eff = has_left ? first_up_reg : s_item.upper_pixel;
    assign first_lo_eff = has_left ? first_lo_reg : s_item.lower_pixel;
    assign cnt_prev     = cnt_reg - CNT_W'(1);
    assign col_cur_ext  = {{COL_W{1'b0}}, cnt_reg};
    assign col_prev_ext = {{COL_W{1'b0}}, cnt_prev};

    always_comb begin
        job_left.left_up  = prev_up_reg;
        job_left.right_up = s_item.upper_pixel;
        job_left.left_lo  = prev_lo_reg;
        job_left.right_lo = s_item.lower_pixel;
        job_left.column   = col_prev_ext[COL_W-1:0];
        job_left.row_out  = s_item.row_index;
        job_left.last     = 1'b0;

        // row end wraps the right neighbour back to column 0
        job_end.left_up   = s_item.upper_pixel;
        job_end.right_up  = first_up_eff;
        job_end.left_lo   = s_item.lower_pixel;
        job_end.right_lo  = first_lo_eff;
        job_end.column    = col_cur_ext[COL_W-1:0];
        job_end.row_out   = s_item.row_index;
        job_end.last      = 1'b1;
    end

    always_comb begin
        cnt_next      = cnt_reg;
        prev_up_next  = prev_up_reg;
        prev_lo_next  = prev_lo_reg;
        first_up_next = first_up_reg;
        first_lo_next = first_lo_reg;
        pend_cnt_next = pend_cnt_reg;
        pend_a_next   = pend_a_reg;
        pend_b_next   = pend_b_reg;

        if (push) begin
            pend_a_next   = pend_b_reg;
            pend_cnt_next = pend_cnt_reg - 2'd1;
        end

        if (accept) begin
            prev_up_next = s_item.upper_pixel;
            prev_lo_next = s_item.lower_pixel;
            if (!has_left) begin
                first_up_next = s_item.upper_pixel;
                first_lo_next = s_item.lower_pixel;
            end
            if (s_item.row_end) begin
                cnt_next = '0;
            end else if (cnt_reg == CNT_LAST) begin
                cnt_next = '0;
            end else begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            pend_a_next   = has_left ? job_left : job_end;
            pend_b_next   = job_end;
            pend_cnt_next = {1'b0, has_left} + {1'b0, s_item.row_end};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            prev_up_reg  <= '0;
            prev_lo_reg  <= '0;
            first_up_reg <= '0;
            first_lo_reg <= '0;
            pend_cnt_reg <= 2'd0;
        end else begin
            cnt_reg      <= cnt_next;
            prev_up_reg  <= prev_up_next;
            prev_lo_reg  <= prev_lo_next;
            first_up_reg <= first_up_next;
            first_lo_reg <= first_lo_next;
            pend_cnt_reg <= pend_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_a_reg <= pend_a_next;
        pend_b_reg <= pend_b_next;
    end

endmodule

>>> rtl/core/pabu_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pabu_queue
// Short job queue that lets the front and the blend pipeline stall apart.
// ----------------------------------------------------------------------------
module pabu_queue import pabu_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  pabu_job_t wr_job,
    output logic      rd_valid,
    input  logic      rd_ready,
    output pabu_job_t rd_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    pabu_job_t        slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (cnt_reg != CNT_FULL);
    assign rd_valid = (cnt_reg != '0);
    assign rd_job   = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({do_wr, do_rd})
            2'b10:   cnt_next = cnt_reg + CNT_W'(1);
            2'b01:   cnt_next = cnt_reg - CNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

>>> rtl/core/pabu_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pabu_blend
// Two-stage blend pipeline: vertical mixes of both columns, then the
// horizontal mix into the output register.
// ----------------------------------------------------------------------------
module pabu_blend import pabu_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [WGT_W-1:0] weight,
    input  logic             job_valid,
    output logic             job_ready,
    input  pabu_job_t        job,
    output logic             m_valid,
    input  logic             m_ready,
    output pabu_out_t        m_item
);

    logic             v1_reg,   v1_next;
    logic [31:0]      s0_reg;
    logic [31:0]      s1_reg;
    logic [COL_W-1:0] col1_reg;
    logic [ROW_W-1:0] row1_reg;
    logic             last1_reg;
    logic             mv_reg,   mv_next;
    pabu_out_t        out_reg;
    logic             en_out;
    logic             en1;

    assign en_out    = !mv_reg || m_ready;
    assign en1       = !v1_reg || en_out;
    assign job_ready = en1;
    assign m_valid   = mv_reg;
    assign m_item    = out_reg;

    always_comb begin
        v1_next = v1_reg;
        mv_next = mv_reg;
        if (en1) begin
            v1_next = job_valid;
        end
        if (en_out) begin
            mv_next = v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            mv_reg <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            s0_reg    <= mix_pair(job.left_up, job.left_lo, weight);
            s1_reg    <= mix_pair(job.right_up, job.right_lo, weight);
            col1_reg  <= job.column;
            row1_reg  <= job.row_out;
            last1_reg <= job.last;
        end
        if (en_out) begin
            out_reg.pixel   <= mix_pair(s0_reg, s1_reg, weight);
            out_reg.column  <= col1_reg;
            out_reg.row_out <= row1_reg;
            out_reg.last    <= last1_reg;
        end
    end

endmodule
